/* design/mbhb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbhb_pkg: shared types and constants for the byte hash bucket block
// Hash widths, the multiplier constant and the control/status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbhb_pkg;

  localparam int HASH_W   = 64;
  localparam int HALF_W   = HASH_W / 2;
  localparam int COUNT_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int STEP_W   = $clog2(HASH_W);

  localparam logic [HALF_W-1:0] HASH_MULT = 32'h9e37_79b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start_sum;     // latch hash + byte
    logic start_div;     // load divider from hash, clear hash (empty byte on last)
    logic mul_lo;        // low partial product
    logic mul_hi_hash;   // finish product into the hash
    logic mul_hi_div;    // finish product into the divider, clear hash
    logic div_step;      // one restoring-division step
    logic out_load;      // move remainder into the output register
  } mbhb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;      // current step is the last one
    logic out_free;      // output register can take a result this cycle
  } mbhb_status_t;

endpackage

/* design/mbhb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbhb_ctrl: sequencer for the byte hash bucket block
// Steps each byte through the split multiply and each finished key through
// the bit-serial modulo, then hands the remainder to the output register.
// ----------------------------------------------------------------------------
module mbhb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_present,
  input  logic                  in_last,
  output logic                  in_ready,
  input  mbhb_pkg::mbhb_status_t status,
  output mbhb_pkg::mbhb_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_LO = 5'b00010,
    ST_MUL_HI = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_present) begin
            cmd.start_sum = 1'b1;
            last_nxt      = in_last;
            state_nxt     = ST_MUL_LO;
          end else if (in_last) begin
            cmd.start_div = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        if (last_r) begin
          cmd.mul_hi_div = 1'b1;
          state_nxt      = ST_DIV;
        end else begin
          cmd.mul_hi_hash = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the remainder until the output register drains
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

/* design/mbhb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbhb_datapath: hash, multiplier, divider and output register
// Running hash with a shared 32x32 multiplier, low half then high half, a restoring
// divider one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module mbhb_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mbhb_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  logic [mbhb_pkg::BYTE_W-1:0]         in_byte,
  input  mbhb_pkg::mbhb_cmd_t                 cmd,
  output mbhb_pkg::mbhb_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbhb_pkg::COUNT_W-1:0]        out_data
);

  logic [mbhb_pkg::COUNT_W-1:0]  count_r;
  logic [mbhb_pkg::HASH_W-1:0]   hash_r;
  logic [mbhb_pkg::HASH_W-1:0]   sum_r;
  logic [mbhb_pkg::HASH_W-1:0]   acc_r;
  logic [mbhb_pkg::HASH_W-1:0]   dvd_r;
  logic [mbhb_pkg::COUNT_W-1:0]  rem_r;
  logic [mbhb_pkg::STEP_W-1:0]   step_r;
  logic [mbhb_pkg::COUNT_W-1:0]  out_data_r;
  logic                          out_valid_r;

  logic [mbhb_pkg::HALF_W-1:0]   mul_opnd;
  logic [mbhb_pkg::HASH_W-1:0]   mul_prod;
  logic [mbhb_pkg::HASH_W-1:0]   prod_full;
  logic [mbhb_pkg::COUNT_W:0]    rem_sh;
  logic [mbhb_pkg::COUNT_W:0]    rem_sub;
  logic [mbhb_pkg::COUNT_W-1:0]  rem_nxt;

  // low half of the sum first, high half on the next cycle
  assign mul_opnd  = cmd.mul_lo ? sum_r[mbhb_pkg::HALF_W-1:0]
                                : sum_r[mbhb_pkg::HASH_W-1:mbhb_pkg::HALF_W];
  assign mul_prod  = {{mbhb_pkg::HALF_W{1'b0}}, mul_opnd}
                   * {{mbhb_pkg::HALF_W{1'b0}}, mbhb_pkg::HASH_MULT};
  assign prod_full = acc_r + {mul_prod[mbhb_pkg::HALF_W-1:0], {mbhb_pkg::HALF_W{1'b0}}};

  // remainder stays below the divisor, so one extra bit covers the shift
  assign rem_sh  = {rem_r, dvd_r[mbhb_pkg::HASH_W-1]};
  assign rem_sub = rem_sh - {1'b0, count_r};
  assign rem_nxt = rem_sub[mbhb_pkg::COUNT_W] ? rem_sh[mbhb_pkg::COUNT_W-1:0]
                                              : rem_sub[mbhb_pkg::COUNT_W-1:0];

  assign status.div_done = (step_r == mbhb_pkg::STEP_W'(mbhb_pkg::HASH_W - 1));
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= mbhb_pkg::COUNT_W'(1);
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd.mul_hi_hash) begin
        hash_r <= prod_full;
      end else if (cmd.mul_hi_div || cmd.start_div) begin
        hash_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sum) begin
      sum_r <= hash_r + mbhb_pkg::HASH_W'(in_byte);
    end
    if (cmd.mul_lo) begin
      acc_r <= mul_prod;
    end
    if (cmd.mul_hi_div || cmd.start_div) begin
      dvd_r  <= cmd.mul_hi_div ? prod_full : hash_r;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[mbhb_pkg::HASH_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      step_r <= step_r + mbhb_pkg::STEP_W'(1);
    end
    if (cmd.out_load) begin
      // a zero bucket count reads as bucket 0
      out_data_r <= (count_r == '0) ? '0 : rem_r;
    end
  end

endmodule

/* design/multiplicative_byte_hash_bucket.sv */
`timescale 1ns / 1ps
// A key byte passes the add, then the low and high partial product on one 32x32
//   multiplier; in_tready stays low while the byte is in work.
// A last item also runs through the 64-step restoring divider before its result
//   shows; an empty last item skips the add and the multiply.
// Reset: hash cleared, bucket_count back to 1, output register empty.
// ----------------------------------------------------------------------------
// multiplicative_byte_hash_bucket: byte stream hash to bucket index
// Multiplicative hash over a key's bytes, reduced modulo the bucket count.
// ----------------------------------------------------------------------------
module multiplicative_byte_hash_bucket (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mbhb_pkg::COUNT_W-1:0]       cfg_wr_data,   // bucket_count
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mbhb_pkg::BYTE_W-1:0]        in_tdata,      // data_byte
  input  logic                               in_tuser,      // byte_present
  input  logic                               in_tlast,      // last_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mbhb_pkg::COUNT_W-1:0]       out_tdata      // bucket_index
);

  mbhb_pkg::mbhb_cmd_t    cmd;
  mbhb_pkg::mbhb_status_t status;

  mbhb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_present (in_tuser),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mbhb_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

/* design/mbhb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbhb_checker: port-level checks for the byte hash bucket block
// Tracks the bucket count from the configuration port and checks results
// against it, plus stall and reset behavior.
// ----------------------------------------------------------------------------
module mbhb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_wr_en,
  input logic [mbhb_pkg::COUNT_W-1:0]  cfg_wr_data,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          in_tuser,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mbhb_pkg::COUNT_W-1:0]  out_tdata
);

  logic [mbhb_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= mbhb_pkg::COUNT_W'(1);
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (count_r != '0) |-> out_tdata < count_r)
    else $error("bucket index not below bucket count");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (count_r == '0) |-> out_tdata == '0)
    else $error("nonzero bucket index with zero bucket count");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser || in_tlast) |=> !in_tready)
    else $error("ready while an item is still in work");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind multiplicative_byte_hash_bucket mbhb_checker u_mbhb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .in_tuser    (in_tuser),
  .in_tlast    (in_tlast),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata)
);
